// ===== rtl/core/lruk_pkg.sv =====
`timescale 1ns / 1ps
package lruk_pkg;
	localparam int FRAME_COUNT = 64;
	localparam int K_MAX       = 8;
	localparam int STAMP_WIDTH = 32;
	localparam int FRAME_W     = $clog2(FRAME_COUNT);
	localparam int SLOT_W      = (K_MAX > 1) ? $clog2(K_MAX) : 1;
	localparam int CNT_W       = $clog2(K_MAX + 1);
	localparam int TOTAL_W     = $clog2(FRAME_COUNT + 1);
	localparam int MEM_W       = FRAME_W + SLOT_W;

	localparam logic [2:0] MODE_ACCESS = 3'd0;
	localparam logic [2:0] MODE_SETEV  = 3'd1;
	localparam logic [2:0] MODE_REMOVE = 3'd2;
	localparam logic [2:0] MODE_EVICT  = 3'd3;
	localparam logic [2:0] MODE_SIZE   = 3'd4;

	localparam logic [1:0] ST_DONE = 2'd0;
	localparam logic [1:0] ST_NONE = 2'd1;
	localparam logic [1:0] ST_BAD  = 2'd2;

	localparam logic [0:0] REG_K      = 1'b0;
	localparam logic [0:0] REG_FRAMES = 1'b1;

	typedef enum logic [2:0] {
		S_IDLE, S_DECIDE, S_SCAN, S_CMP, S_DONE
	} state_t;
endpackage

// ===== rtl/core/lru_k_frame_replacer.sv =====
`timescale 1ns / 1ps
// LRU-K replacer over 64 frames, one command at a time. Access, mark change, remove and size
// query go from the decide state straight to the result strobe; evict first runs a scan that,
// in a scan state and a compare state per frame, reads each frame's k-th (or oldest) stamp
// from the stamp memory and compares it in one shared comparator. busy is high from the accepting edge
// until the result strobe. Results appear for one cycle with done high and cannot be
// stalled, so the receiver must take every one.
module lru_k_frame_replacer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  mode,
	input  logic [5:0]  frame_idx,
	input  logic        evictable_flag,
	output logic        done,
	output logic [1:0]  status,
	output logic [5:0]  victim_frame,
	output logic [6:0]  evictable_count,
	output logic        time_overflow
);
	localparam int FW = lruk_pkg::FRAME_W;
	localparam int SW = lruk_pkg::SLOT_W;
	localparam int CW = lruk_pkg::CNT_W;
	localparam int TW = lruk_pkg::TOTAL_W;
	localparam int DW = lruk_pkg::STAMP_WIDTH;
	localparam int NF = lruk_pkg::FRAME_COUNT;

	logic [3:0] k_q;
	logic [6:0] fiu_q;
	lruk_pkg::state_t state_q, state_d;
	logic [2:0] mode_q;
	logic [FW-1:0] fid_q;
	logic flag_q;
	logic [SW-1:0] head_q [NF];
	logic [CW-1:0] cnt_q [NF];
	logic [NF-1:0] ev_q;
	logic [TW-1:0] total_q;
	logic [DW-1:0] clock_q;
	logic ovf_q;
	logic [FW:0] scan_q;
	logic [FW-1:0] cur_q;
	logic cur_inf_q, cur_ok_q;
	logic found_q, best_inf_q;
	logic [DW-1:0] best_stamp_q;
	logic [FW-1:0] best_q;
	logic [1:0] st_q;
	logic [FW-1:0] vic_q;
	logic [DW-1:0] mem [NF*lruk_pkg::K_MAX];
	logic [DW-1:0] rd_q;
	logic [CW-1:0] keff;
	logic wr_cfg;

	assign pready = 1'b1;
	assign wr_cfg = psel && penable && pwrite;
	always_comb begin
		if (k_q == 4'd0) keff = CW'(1);
		else if (32'(k_q) > lruk_pkg::K_MAX) keff = CW'(lruk_pkg::K_MAX);
		else keff = CW'(k_q);
	end
	always_comb begin
		unique case (paddr[2])
			lruk_pkg::REG_K: prdata = {28'd0, k_q};
			default:         prdata = {25'd0, fiu_q};
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q <= 4'd2;
			fiu_q <= 7'd64;
		end else if (wr_cfg) begin
			if (paddr[2] == lruk_pkg::REG_K) k_q <= pwdata[3:0];
			else fiu_q <= pwdata[6:0];
		end
	end

	// scan read: slot of the k-th (or oldest) stamp of frame scan_q
	logic [FW-1:0] sf;
	logic [CW-1:0] sback;
	logic sinf;
	logic [SW-1:0] sslot;
	assign sf = scan_q[FW-1:0];
	assign sinf = cnt_q[sf] < keff;
	assign sback = sinf ? cnt_q[sf] : keff;
	assign sslot = SW'(32'(head_q[sf]) + lruk_pkg::K_MAX - 32'(sback));

	logic frame_ok, mem_we;
	assign frame_ok = (7'(fid_q) < fiu_q);
	assign mem_we = (state_q == lruk_pkg::S_DECIDE) && mode_q == lruk_pkg::MODE_ACCESS
		&& frame_ok;
	always_ff @(posedge clk) begin
		if (mem_we) mem[{fid_q, head_q[fid_q]}] <= clock_q;
		rd_q <= mem[{sf, sslot}];
	end

	logic better;
	assign better = !found_q || (cur_inf_q && !best_inf_q)
		|| (cur_inf_q == best_inf_q && rd_q < best_stamp_q);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			lruk_pkg::S_IDLE: if (start) state_d = lruk_pkg::S_DECIDE;
			lruk_pkg::S_DECIDE: state_d = (mode_q == lruk_pkg::MODE_EVICT) ?
				lruk_pkg::S_SCAN : lruk_pkg::S_DONE;
			lruk_pkg::S_SCAN: state_d = scan_q[FW] ? lruk_pkg::S_DONE : lruk_pkg::S_CMP;
			lruk_pkg::S_CMP: state_d = lruk_pkg::S_SCAN;
			lruk_pkg::S_DONE: state_d = lruk_pkg::S_IDLE;
			default: state_d = lruk_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lruk_pkg::S_IDLE;
			for (int i = 0; i < NF; i++) begin
				head_q[i] <= '0;
				cnt_q[i] <= '0;
			end
			ev_q <= '0;
			total_q <= '0;
			clock_q <= '0;
			ovf_q <= 1'b0;
			scan_q <= '0;
			found_q <= 1'b0;
			st_q <= lruk_pkg::ST_NONE;
			vic_q <= '0;
			mode_q <= '0;
			fid_q <= '0;
			flag_q <= 1'b0;
			cur_q <= '0;
			cur_inf_q <= 1'b0;
			cur_ok_q <= 1'b0;
			best_inf_q <= 1'b0;
			best_stamp_q <= '0;
			best_q <= '0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				lruk_pkg::S_IDLE: if (start) begin
					mode_q <= mode;
					fid_q <= frame_idx;
					flag_q <= evictable_flag;
					scan_q <= '0;
					found_q <= 1'b0;
				end
				lruk_pkg::S_DECIDE: begin
					st_q <= lruk_pkg::ST_NONE;
					vic_q <= '0;
					if (mode_q <= lruk_pkg::MODE_REMOVE && !frame_ok) begin
						st_q <= lruk_pkg::ST_BAD;
					end else begin
						case (mode_q)
							lruk_pkg::MODE_ACCESS: begin
								head_q[fid_q] <= SW'((32'(head_q[fid_q]) + 1)
									% lruk_pkg::K_MAX);
								cnt_q[fid_q] <= (cnt_q[fid_q] + CW'(1) < keff) ?
									cnt_q[fid_q] + CW'(1) : keff;
								if (clock_q != '1) begin
									clock_q <= clock_q + DW'(1);
									if (clock_q + DW'(1) == '1) ovf_q <= 1'b1;
								end else ovf_q <= 1'b1;
								st_q <= lruk_pkg::ST_DONE;
							end
							lruk_pkg::MODE_SETEV: if (cnt_q[fid_q] != '0
									&& ev_q[fid_q] != flag_q) begin
								ev_q[fid_q] <= flag_q;
								if (flag_q) total_q <= total_q + TW'(1);
								else if (total_q != '0) total_q <= total_q - TW'(1);
								st_q <= lruk_pkg::ST_DONE;
							end
							lruk_pkg::MODE_REMOVE: if (cnt_q[fid_q] != '0) begin
								if (ev_q[fid_q]) begin
									head_q[fid_q] <= '0;
									cnt_q[fid_q] <= '0;
									ev_q[fid_q] <= 1'b0;
									if (total_q != '0) total_q <= total_q - TW'(1);
									st_q <= lruk_pkg::ST_DONE;
								end else st_q <= lruk_pkg::ST_BAD;
							end
							lruk_pkg::MODE_SIZE: st_q <= lruk_pkg::ST_DONE;
							default: ;
						endcase
					end
				end
				lruk_pkg::S_SCAN: begin
					cur_q <= sf;
					cur_inf_q <= sinf;
					cur_ok_q <= !scan_q[FW] && cnt_q[sf] != '0 && ev_q[sf];
					if (!scan_q[FW]) scan_q <= scan_q + (FW+1)'(1);
					else if (found_q) begin
						head_q[best_q] <= '0;
						cnt_q[best_q] <= '0;
						ev_q[best_q] <= 1'b0;
						if (total_q != '0) total_q <= total_q - TW'(1);
						vic_q <= best_q;
						st_q <= lruk_pkg::ST_DONE;
					end
				end
				lruk_pkg::S_CMP: if (cur_ok_q && better) begin
					found_q <= 1'b1;
					best_inf_q <= cur_inf_q;
					best_stamp_q <= rd_q;
					best_q <= cur_q;
				end
				default: ;
			endcase
		end
	end

	assign busy = (state_q != lruk_pkg::S_IDLE);
	assign done = (state_q == lruk_pkg::S_DONE);
	assign status = st_q;
	assign victim_frame = vic_q;
	assign evictable_count = 7'(total_q);
	assign time_overflow = ovf_q;
endmodule
